// ===== src/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

	// Width of the capacity register and the most items it can ask for.
	localparam int CAP_W     = 4;
	localparam int MAX_ITEMS = (1 << CAP_W) - 1;
	localparam int DATA_W    = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	// Command codes; codes five to seven are refused.
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	// Input word.
	typedef struct packed {
		logic [2:0] command;
		word_t      value;
	} in_word_t;

	// Output word.
	typedef struct packed {
		logic  ok;
		word_t front_value;
		word_t rear_value;
		logic  is_empty;
		logic  is_full;
	} out_word_t;

	// Controls broadcast to every cell of the row.
	typedef struct packed {
		logic clear;
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} cdq_ctl_t;

endpackage

// ===== src/cdq_cell.sv =====
`timescale 1ns / 1ps

module cdq_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  cdq_pkg::cdq_ctl_t ctl,
	input  cdq_pkg::word_t   value,
	input  cdq_pkg::word_t   left_data,
	input  logic             left_occ,
	input  cdq_pkg::word_t   right_data,
	input  logic             right_occ,
	output cdq_pkg::word_t   data,
	output logic             occ,
	output cdq_pkg::word_t   tap
);
	import cdq_pkg::*;

	word_t data_q;
	logic  occ_q;

	// Occupancy moves with the row on front commands and flips at the rear edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.push_front) begin
			occ_q <= left_occ;
		end else if (ctl.pop_front) begin
			occ_q <= right_occ;
		end else if (ctl.push_rear && !occ_q && left_occ) begin
			occ_q <= 1'b1;
		end else if (ctl.pop_rear && occ_q && !right_occ) begin
			occ_q <= 1'b0;
		end
	end

	// Item data shifts toward the rear on a front insert and toward the front on a front removal.
	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_rear && !occ_q && left_occ) begin
			data_q <= value;
		end
	end

	assign data = data_q;
	assign occ  = occ_q;

	// The last occupied cell presents its item for the rear read.
	assign tap = (occ_q && !right_occ) ? data_q : '0;

endmodule

// ===== src/circular_deque.sv =====
`timescale 1ns / 1ps

// Channel   Signals                     Direction  Content
// config    cfg_we, cfg_data            in         capacity, clears the deque
// command   in_valid, in_ready, in_data in         command and value
// result    out_valid, out_ready, out_data out     ok, front, rear, empty, full
//
// One command is taken per cycle while in_ready is high; the whole cell row updates in that cycle.
// The result word appears in the cycle after the command is accepted.
// A new command is taken while the result register is empty or being read.
// While a result is stalled the row holds, so the word stays unchanged, unless a capacity write clears the deque.
// Reset empties the deque and sets capacity to fifteen; no clearing pass.

module circular_deque #(
	parameter int RING_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdq_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cdq_pkg::out_word_t  out_data
);
	import cdq_pkg::*;

	localparam int NCELLS = (RING_SLOTS - 1 < MAX_ITEMS) ? RING_SLOTS - 1 : MAX_ITEMS;

	logic [CAP_W-1:0] capacity_q;
	logic             out_valid_q;
	logic             ok_q;
	logic             accept;
	logic             empty;
	logic             full;
	logic             ok;
	logic [CAP_W-1:0] eff_cap;
	logic [NCELLS-1:0] occ;
	logic [NCELLS-1:0] full_vec;
	word_t            data_w [NCELLS];
	word_t            tap_w  [NCELLS];
	word_t            rear_sel;
	cdq_ctl_t         ctl;

	// Capacity register; a write also empties the deque through the clear control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(MAX_ITEMS);
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// Usable capacity is bounded by the number of cells.
	assign eff_cap = (capacity_q > CAP_W'(NCELLS)) ? CAP_W'(NCELLS) : capacity_q;

	// Full when usable capacity is zero or the cell at position usable capacity minus one holds an item.
	genvar g;
	generate
		for (g = 0; g < NCELLS; g++) begin : g_full
			assign full_vec[g] = occ[g] && (eff_cap == CAP_W'(g + 1));
		end
	endgenerate

	assign empty = !occ[0];
	assign full  = (eff_cap == '0) || (|full_vec);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Command decode into row controls and the success flag.
	always_comb begin
		ctl       = '0;
		ctl.clear = cfg_we;
		ok        = 1'b0;
		case (in_data.command)
			CMD_PUSH_FRONT: begin
				ok             = !full;
				ctl.push_front = accept && !full;
			end
			CMD_PUSH_REAR: begin
				ok            = !full;
				ctl.push_rear = accept && !full;
			end
			CMD_POP_FRONT: begin
				ok            = !empty;
				ctl.pop_front = accept && !empty;
			end
			CMD_POP_REAR: begin
				ok           = !empty;
				ctl.pop_rear = accept && !empty;
			end
			CMD_PEEK: begin
				ok = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Row of cells, front item in cell zero.
	generate
		for (g = 0; g < NCELLS; g++) begin : g_cell
			word_t left_data;
			logic  left_occ;
			word_t right_data;
			logic  right_occ;

			if (g == 0) begin : g_first
				assign left_data = in_data.value;
				assign left_occ  = 1'b1;
			end else begin : g_mid
				assign left_data = data_w[g-1];
				assign left_occ  = occ[g-1];
			end

			if (g == NCELLS - 1) begin : g_last
				assign right_data = '0;
				assign right_occ  = 1'b0;
			end else begin : g_inner
				assign right_data = data_w[g+1];
				assign right_occ  = occ[g+1];
			end

			cdq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.value      (in_data.value),
				.left_data  (left_data),
				.left_occ   (left_occ),
				.right_data (right_data),
				.right_occ  (right_occ),
				.data       (data_w[g]),
				.occ        (occ[g]),
				.tap        (tap_w[g])
			);
		end
	endgenerate

	// Only the last occupied cell drives its tap, so an OR picks the rear item.
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < NCELLS; i++) begin
			rear_sel = rear_sel | tap_w[i];
		end
	end

	// Result register holds the valid flag and the success bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q <= ok;
		end
	end

	// The remaining fields come from the row, which holds still while a word waits unless a capacity write clears it.
	assign out_valid            = out_valid_q;
	assign out_data.ok          = ok_q;
	assign out_data.front_value = empty ? -32'sd1 : data_w[0];
	assign out_data.rear_value  = empty ? -32'sd1 : rear_sel;
	assign out_data.is_empty    = empty;
	assign out_data.is_full     = full;

	// Occupied cells always form an unbroken run from the front.
	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		(occ & (occ + NCELLS'(1))) == '0)
		else $error("occupancy has a gap");

	// A refused insert leaves the row occupancy untouched.
	a_refused_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && !cfg_we &&
		 (in_data.command == CMD_PUSH_FRONT || in_data.command == CMD_PUSH_REAR))
		|=> $stable(occ))
		else $error("refused insert changed occupancy");

	// A successful rear insert leaves the deque non-empty.
	a_push_rear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push_rear && !cfg_we |=> !empty)
		else $error("rear insert left the deque empty");

	// A configuration write empties the deque.
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> empty)
		else $error("capacity write did not empty the deque");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import cdq_pkg::*;

	localparam int RING_SLOTS = 16;

	// Command codes that the block must refuse.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS   = 155;

	// Tracks the deque contents and holds the result words still owed by the block.
	class deque_tracker;
		word_t       ring[RING_SLOTS];
		int          head;
		int          tail;
		logic [3:0]  capacity;
		out_word_t   pending_results[$];
		int          fail_count;

		function new();
			foreach (ring[i]) ring[i] = '0;
			head = 0;
			tail = 0;
			capacity = 4'(MAX_ITEMS);
			fail_count = 0;
		endfunction

		// A capacity write empties the deque but keeps the slot contents.
		function void set_capacity(logic [3:0] c);
			capacity = c;
			head = 0;
			tail = 0;
		endfunction

		function int ring_len();
			int m;
			m = int'(capacity) + 1;
			if (m > RING_SLOTS) begin
				m = RING_SLOTS;
			end
			return m;
		endfunction

		function int step_up(int i, int m);
			return (i + 1 >= m) ? 0 : i + 1;
		endfunction

		function int step_down(int i, int m);
			return (i == 0 || i >= m) ? m - 1 : i - 1;
		endfunction

		// Apply one accepted command and queue the word it must produce.
		function void note_command(in_word_t w);
			int        m;
			bit        empty;
			bit        full;
			out_word_t res;
			m = ring_len();
			empty = (head == tail);
			full = (step_up(tail, m) == head);
			res = '0;
			case (w.command)
				CMD_PUSH_FRONT: begin
					if (!full) begin
						head = step_down(head, m);
						ring[head] = w.value;
						res.ok = 1'b1;
					end
				end
				CMD_PUSH_REAR: begin
					if (!full) begin
						ring[tail] = w.value;
						tail = step_up(tail, m);
						res.ok = 1'b1;
					end
				end
				CMD_POP_FRONT: begin
					if (!empty) begin
						head = step_up(head, m);
						res.ok = 1'b1;
					end
				end
				CMD_POP_REAR: begin
					if (!empty) begin
						tail = step_down(tail, m);
						res.ok = 1'b1;
					end
				end
				CMD_PEEK: begin
					res.ok = 1'b1;
				end
				default: begin
					res.ok = 1'b0;
				end
			endcase
			res.is_empty = (head == tail);
			res.is_full = (step_up(tail, m) == head);
			if (res.is_empty) begin
				res.front_value = -1;
				res.rear_value = -1;
			end else begin
				res.front_value = ring[head];
				res.rear_value = ring[step_down(tail, m)];
			end
			pending_results.push_back(res);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				fail_count++;
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (pending_results.size() == 0) begin
				$error("result word arrived with no command outstanding");
				fail_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("ok", want.ok, got.ok);
			compare_field("front_value", want.front_value, got.front_value);
			compare_field("rear_value", want.rear_value, got.rear_value);
			compare_field("is_empty", want.is_empty, got.is_empty);
			compare_field("is_full", want.is_full, got.is_full);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	in_word_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_word_t  out_data;

	bit tx_quiet;
	bit rx_quiet;

	deque_tracker tracker = new();

	circular_deque #(
		.RING_SLOTS(RING_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic in_word_t make_word(logic [2:0] c, word_t v);
		in_word_t w;
		w.command = c;
		w.value = v;
		return w;
	endfunction

	// Mostly full-range values, with the extremes mixed in now and then.
	function automatic word_t random_value();
		case ($urandom_range(0, 15))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -1;
			3: return 0;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Command mix leans toward inserts or removals by fill_pct.
	function automatic in_word_t random_command(int fill_pct);
		int         r;
		logic [2:0] c;
		r = $urandom_range(0, 99);
		if (r < fill_pct) begin
			c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
		end else if (r < 90) begin
			c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
		end else if (r < 96) begin
			c = CMD_PEEK;
		end else begin
			c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		return make_word(c, random_value());
	endfunction

	// Present one word after a random gap and hold it until it is taken.
	task automatic send_word(in_word_t w);
		int gap;
		gap = draw_wait(tx_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = w;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.note_command(w);
	endtask

	// Stop sending and wait for every owed result word.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [3:0] c);
		drain_results();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = c;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_capacity(c);
	endtask

	// Result side: random stall before each word, then check it when taken.
	initial begin
		int stall;
		out_ready = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(rx_quiet);
			if (stall != 0) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
				out_ready = 1'b1;
			end
			do @(posedge clk); while (!out_valid);
			tracker.check_result(out_data);
		end
	end

	// Stimulus: directed cases first, then random phases at varied capacities.
	initial begin
		logic [3:0] cap;
		int         fill_pct;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset capacity: removals and peek on an empty deque, extreme values, bad codes.
		send_word(make_word(CMD_PEEK, 0));
		send_word(make_word(CMD_POP_FRONT, 0));
		send_word(make_word(CMD_POP_REAR, 0));
		send_word(make_word(CMD_PUSH_FRONT, 32'sh7FFF_FFFF));
		send_word(make_word(CMD_PUSH_REAR, 32'sh8000_0000));
		send_word(make_word(CMD_PUSH_FRONT, -1));
		send_word(make_word(CMD_PUSH_REAR, 0));
		send_word(make_word(CMD_UNUSED_LO, 32'sh5555_5555));
		send_word(make_word(CMD_UNUSED_HI, 32'shAAAA_AAAA));
		send_word(make_word(CMD_POP_FRONT, 0));
		send_word(make_word(CMD_POP_REAR, 0));

		// Capacity one: inserts into a full deque are refused.
		write_capacity(4'd1);
		send_word(make_word(CMD_PUSH_REAR, 32'sh1234_5678));
		send_word(make_word(CMD_PUSH_FRONT, 32'sh0BAD_F00D));
		send_word(make_word(CMD_PUSH_REAR, 32'sh0BAD_F00D));
		send_word(make_word(CMD_PEEK, 0));
		send_word(make_word(CMD_POP_REAR, 0));
		send_word(make_word(CMD_POP_FRONT, 0));

		// Capacity zero: the deque is empty and full at once, so every insert and removal is refused.
		write_capacity(4'd0);
		send_word(make_word(CMD_PUSH_FRONT, 32'sh0000_0001));
		send_word(make_word(CMD_PUSH_REAR, 32'sh0000_0002));
		send_word(make_word(CMD_POP_FRONT, 0));
		send_word(make_word(CMD_POP_REAR, 0));
		send_word(make_word(CMD_PEEK, 0));

		// Random phases; each one starts from a fresh capacity write.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0) begin
				cap = 4'd1;
			end else if (p == 1 || p == RANDOM_PHASES - 1) begin
				cap = 4'(MAX_ITEMS);
			end else begin
				cap = 4'($urandom_range(1, MAX_ITEMS));
			end
			write_capacity(cap);
			fill_pct = 50;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 24 == 0) begin
					case ($urandom_range(0, 2))
						0: fill_pct = 25;
						1: fill_pct = 50;
						default: fill_pct = 80;
					endcase
				end
				if (i % 40 == 0) begin
					tx_quiet = ($urandom_range(0, 3) == 0);
					rx_quiet = ($urandom_range(0, 3) == 0);
				end
				// Once mid-phase, hold off until the result side has caught up.
				if (p == 2 && i == PHASE_WORDS / 2) begin
					drain_results();
				end
				send_word(random_command(fill_pct));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
